>>> rtl/lz_backref_decompressor_assert.svh
// Assertion macros shared by the lz back-reference decompressor RTL.
`ifndef LZ_BACKREF_DECOMPRESSOR_ASSERT_SVH
`define LZ_BACKREF_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LZB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LZB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lzbd_pkg.sv
// Shared types and constants for the lz back-reference decompressor.
package lzbd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int OUT_LANES_DEF   = 8;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int SIZE_W    = 24;     // output_size register width
    localparam int LINK_W    = 16;
    localparam int DIST_W    = 12;     // distance-minus-one field
    localparam int NIB_W     = 4;      // length code field
    localparam int LEN_W     = 9;      // longest copy is 255 + 18
    localparam int OUT_W     = 64;
    localparam int CNT_W     = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int LEN_BIAS_SHORT = 2;
    localparam int LEN_BIAS_LONG  = 'h12;

    // Register map, indexed by paddr[2]
    localparam logic REG_OUTPUT_SIZE    = 1'b0;
    localparam logic REG_OVERFLOW_CHECK = 1'b1;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAR  = 2'd1,
        ST_OVF  = 2'd2,
        ST_DONE = 2'd3
    } t_status;

endpackage

>>> rtl/lz_backref_decompressor.sv
// Top level of the lz back-reference (Yay0-style) token decompressor.
//
// Input channel: one transaction per token (literal or copy), taken when
// i_in_valid is high and o_in_stall is low. The block works on one token
// at a time; o_in_stall is high from acceptance until its last result has
// been loaded into the output register.
// Output channel: results of up to OUT_LANES bytes, first byte in bits 7:0,
// o_last on the final result of a token, taken when o_out_valid is high and
// i_out_stall is low. A held result does not change; the core waits in its
// emit step until the output register frees up.
// Steps: each token is decoded, then emitted; a copy within range is read
// before each emit step. The history RAM gives one read and one write per
// cycle, so a copy moves one byte per cycle in its read step; the read is
// registered, and the emit step waits while the output register is held.
// Configuration (APB, output_size at 0x0, overflow_check at 0x4) must be
// written only while idle; the block itself does not enforce this. Reset
// (synchronous, active low) clears the written count, the sticky error and
// the registers (output_size 0, overflow_check 1); the history RAM is not
// cleared, distance checks keep stale bytes unread.
`include "lz_backref_decompressor_assert.svh"

module lz_backref_decompressor #(
    parameter int WINDOW_SIZE = lzbd_pkg::WINDOW_SIZE_DEF,
    parameter int OUT_LANES   = lzbd_pkg::OUT_LANES_DEF,
    parameter int COUNT_BITS  = lzbd_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // token channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_start_stream,
    input  logic                           i_is_literal,
    input  logic [7:0]                     i_literal_byte,
    input  logic [lzbd_pkg::LINK_W-1:0]    i_link_word,
    input  logic [7:0]                     i_extra_length,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lzbd_pkg::OUT_W-1:0]     o_out_bytes,
    output logic [lzbd_pkg::CNT_W-1:0]     o_byte_count,
    output logic                           o_last,
    output logic [1:0]                     o_status,
    output logic                           o_finished,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lzbd_pkg::APB_AW-1:0]    paddr,
    input  logic [lzbd_pkg::APB_DW-1:0]    pwdata,
    output logic [lzbd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    localparam int AW     = $clog2(WINDOW_SIZE);
    localparam int LANE_W = $clog2(OUT_LANES + 1);
    localparam int IDX_W  = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
    localparam int CMP_W  = ((COUNT_BITS > lzbd_pkg::SIZE_W) ? COUNT_BITS
                                                              : lzbd_pkg::SIZE_W) + 1;
    localparam int DST_W  = lzbd_pkg::DIST_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_EMIT
    } t_state;

    // control state
    t_state                         r_state,     n_state;
    logic [COUNT_BITS-1:0]          r_wc,        n_wc;
    logic                           r_err,       n_err;
    logic [lzbd_pkg::SIZE_W-1:0]    r_osize,     n_osize;
    logic                           r_ovf_chk,   n_ovf_chk;
    logic                           r_rd_pend,   n_rd_pend;
    logic                           r_out_valid, n_out_valid;
    logic                           r_fwd_hit;

    // payload
    logic                           r_tok_lit,   n_tok_lit;
    lzbd_pkg::t_byte                r_tok_byte,  n_tok_byte;
    logic [lzbd_pkg::LINK_W-1:0]    r_tok_link,  n_tok_link;
    lzbd_pkg::t_byte                r_tok_extra, n_tok_extra;
    logic [AW-1:0]                  r_rd_ptr,    n_rd_ptr;
    logic [AW-1:0]                  r_wr_ptr,    n_wr_ptr;
    logic [lzbd_pkg::LEN_W-1:0]     r_remain,    n_remain;
    logic [LANE_W-1:0]              r_iss,       n_iss;
    logic [LANE_W-1:0]              r_lane,      n_lane;
    lzbd_pkg::t_byte                r_pack [OUT_LANES];
    lzbd_pkg::t_byte                n_pack [OUT_LANES];
    lzbd_pkg::t_status              r_status,    n_status;
    lzbd_pkg::t_byte                r_fwd_byte;
    lzbd_pkg::t_byte                r_mem_q;
    logic [lzbd_pkg::OUT_W-1:0]     r_out_bytes, n_out_bytes;
    logic [lzbd_pkg::CNT_W-1:0]     r_out_cnt,   n_out_cnt;
    logic                           r_out_last,  n_out_last;
    lzbd_pkg::t_status              r_out_status, n_out_status;
    logic                           r_out_fin,   n_out_fin;

    // history window
    lzbd_pkg::t_byte                r_hist [WINDOW_SIZE];

    // memory port controls
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    lzbd_pkg::t_byte                wr_data;
    lzbd_pkg::t_byte                rd_byte;

    // decode helpers
    logic                           accept;
    logic                           cfg_wr;
    logic                           out_free;
    logic [CMP_W-1:0]               wc_ext;
    logic [CMP_W-1:0]               os_ext;
    logic                           done;
    logic [DST_W-1:0]               copy_dist;
    logic [lzbd_pkg::NIB_W-1:0]     nib;
    logic [lzbd_pkg::LEN_W-1:0]     len;
    logic [CMP_W-1:0]               end_pos;
    logic [CMP_W-1:0]               room;
    logic [8*OUT_LANES-1:0]         pack_flat;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || !i_out_stall;

    assign wc_ext    = CMP_W'(r_wc);
    assign os_ext    = CMP_W'(r_osize);
    assign done      = (wc_ext >= os_ext);
    assign copy_dist = DST_W'(r_tok_link[lzbd_pkg::DIST_W-1:0]) + DST_W'(1);
    assign nib       = r_tok_link[lzbd_pkg::LINK_W-1 -: lzbd_pkg::NIB_W];
    assign len     = (nib == '0)
                   ? lzbd_pkg::LEN_W'(r_tok_extra) + lzbd_pkg::LEN_W'(lzbd_pkg::LEN_BIAS_LONG)
                   : lzbd_pkg::LEN_W'(nib) + lzbd_pkg::LEN_W'(lzbd_pkg::LEN_BIAS_SHORT);
    assign end_pos = wc_ext + CMP_W'(len);
    assign room    = os_ext - wc_ext;

    // same-edge write to the address just read is forwarded
    assign rd_byte = r_fwd_hit ? r_fwd_byte : r_mem_q;

    always_comb begin
        for (int i = 0; i < OUT_LANES; i++) begin
            pack_flat[8*i +: 8] = r_pack[i];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_wc         = r_wc;
        n_err        = r_err;
        n_osize      = r_osize;
        n_ovf_chk    = r_ovf_chk;
        n_rd_pend    = 1'b0;
        n_out_valid  = r_out_valid;
        n_tok_lit    = r_tok_lit;
        n_tok_byte   = r_tok_byte;
        n_tok_link   = r_tok_link;
        n_tok_extra  = r_tok_extra;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_remain     = r_remain;
        n_iss        = r_iss;
        n_lane       = r_lane;
        n_pack       = r_pack;
        n_status     = r_status;
        n_out_bytes  = r_out_bytes;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_fin    = r_out_fin;
        rd_en        = 1'b0;
        rd_addr      = r_rd_ptr;
        wr_en        = 1'b0;
        wr_addr      = r_wr_ptr;
        wr_data      = rd_byte;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (cfg_wr) begin
            case (paddr[2])
                lzbd_pkg::REG_OUTPUT_SIZE:    n_osize   = pwdata[lzbd_pkg::SIZE_W-1:0];
                lzbd_pkg::REG_OVERFLOW_CHECK: n_ovf_chk = pwdata[0];
                default: ;
            endcase
        end

        // copy data stage: byte read last cycle lands in the pack and the window
        if (r_rd_pend) begin
            wr_en                      = 1'b1;
            n_pack[r_lane[IDX_W-1:0]]  = rd_byte;
            n_lane                     = r_lane + LANE_W'(1);
            n_wr_ptr                   = r_wr_ptr + AW'(1);
            n_wc                       = r_wc + COUNT_BITS'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tok_lit   = i_is_literal;
                    n_tok_byte  = i_literal_byte;
                    n_tok_link  = i_link_word;
                    n_tok_extra = i_extra_length;
                    if (i_start_stream) begin
                        n_wc  = '0;
                        n_err = 1'b0;
                    end
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_iss    = '0;
                n_lane   = '0;
                n_remain = '0;
                n_status = lzbd_pkg::ST_OK;
                n_state  = S_EMIT;
                n_rd_ptr = r_wc[AW-1:0] - copy_dist[AW-1:0];
                n_wr_ptr = r_wc[AW-1:0];
                if (r_err || done) begin
                    n_status = lzbd_pkg::ST_DONE;
                end else if (r_tok_lit) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_wc[AW-1:0];
                    wr_data   = r_tok_byte;
                    n_wc      = r_wc + COUNT_BITS'(1);
                    n_pack[0] = r_tok_byte;
                    n_lane    = LANE_W'(1);
                end else if (CMP_W'(copy_dist) > wc_ext) begin
                    n_err    = 1'b1;
                    n_status = lzbd_pkg::ST_FAR;
                end else if (end_pos > os_ext) begin
                    if (r_ovf_chk) begin
                        n_err    = 1'b1;
                        n_status = lzbd_pkg::ST_OVF;
                    end else begin
                        // cut at output_size; room is below len here
                        n_remain = room[lzbd_pkg::LEN_W-1:0];
                        n_state  = S_READ;
                    end
                end else begin
                    n_remain = len;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                rd_en     = 1'b1;
                n_rd_pend = 1'b1;
                n_rd_ptr  = r_rd_ptr + AW'(1);
                n_remain  = r_remain - lzbd_pkg::LEN_W'(1);
                n_iss     = r_iss + LANE_W'(1);
                if ((r_iss == LANE_W'(OUT_LANES - 1)) ||
                    (r_remain == lzbd_pkg::LEN_W'(1))) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_rd_pend && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_bytes  = lzbd_pkg::OUT_W'(pack_flat);
                    n_out_cnt    = lzbd_pkg::CNT_W'(r_lane);
                    n_out_last   = (r_remain == '0);
                    n_out_status = r_status;
                    n_out_fin    = done;
                    for (int i = 0; i < OUT_LANES; i++) begin
                        n_pack[i] = '0;
                    end
                    n_lane  = '0;
                    n_iss   = '0;
                    n_state = (r_remain == '0) ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wc        <= '0;
            r_err       <= 1'b0;
            r_osize     <= '0;
            r_ovf_chk   <= 1'b1;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            for (int i = 0; i < OUT_LANES; i++) begin
                r_pack[i] <= '0;
            end
            r_lane      <= '0;
        end else begin
            r_state     <= n_state;
            r_wc        <= n_wc;
            r_err       <= n_err;
            r_osize     <= n_osize;
            r_ovf_chk   <= n_ovf_chk;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            r_fwd_hit   <= rd_en && wr_en && (rd_addr == wr_addr);
            r_pack      <= n_pack;
            r_lane      <= n_lane;
        end
        r_fwd_byte   <= wr_data;
        r_tok_lit    <= n_tok_lit;
        r_tok_byte   <= n_tok_byte;
        r_tok_link   <= n_tok_link;
        r_tok_extra  <= n_tok_extra;
        r_rd_ptr     <= n_rd_ptr;
        r_wr_ptr     <= n_wr_ptr;
        r_remain     <= n_remain;
        r_iss        <= n_iss;
        r_status     <= n_status;
        r_out_bytes  <= n_out_bytes;
        r_out_cnt    <= n_out_cnt;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_fin    <= n_out_fin;
    end

    // history RAM: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= wr_data;
        end
        r_mem_q <= r_hist[rd_addr];
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_bytes  = r_out_bytes;
    assign o_byte_count = r_out_cnt;
    assign o_last       = r_out_last;
    assign o_status     = r_out_status;
    assign o_finished   = r_out_fin;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == lzbd_pkg::REG_OVERFLOW_CHECK)
                        ? lzbd_pkg::APB_DW'(r_ovf_chk)
                        : lzbd_pkg::APB_DW'(r_osize);

    `LZB_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, accept, r_state == S_DECODE, "accepted token did not go to decode")
    `LZB_ASSERT_NOW(a_err_no_bytes, i_clk, i_rst_n, o_out_valid && (o_status != lzbd_pkg::ST_OK), (o_byte_count == '0) && o_last, "error result carries bytes or is not last")
    `LZB_ASSERT_NOW(a_partial_is_last, i_clk, i_rst_n, o_out_valid && !o_last, o_byte_count == lzbd_pkg::CNT_W'(OUT_LANES), "non-final result not full")
    `LZB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_out_valid, o_byte_count <= lzbd_pkg::CNT_W'(OUT_LANES), "byte count above lane count")

endmodule
